### sv/psfp_pkg.sv
// shared types and constants for the particle sensor frame parser
// no dependencies
package psfp_pkg;

    localparam logic [7:0] START_BYTE   = 8'hAA;
    localparam logic [7:0] TAIL_BYTE    = 8'hAB;
    localparam logic [7:0] DATA_COMMAND = 8'hC0;

    // frame byte positions
    localparam logic [3:0] POS_HUNT    = 4'd0;
    localparam logic [3:0] POS_COMMAND = 4'd1;
    localparam logic [3:0] POS_DATA0   = 4'd2;
    localparam logic [3:0] POS_DATA3   = 4'd5;
    localparam logic [3:0] POS_SUM     = 4'd8;
    localparam logic [3:0] POS_TAIL    = 4'd9;

    localparam logic [15:0] READING_INVALID = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_DISCARD  = 3'd0,
        ST_IN_FRAME = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_OTHER    = 3'd3,
        ST_SUM_BAD  = 3'd4,
        ST_TAIL_BAD = 3'd5
    } t_frame_status;

    typedef struct packed {
        t_frame_status status;
        logic [15:0]   fine;
        logic [15:0]   coarse;
    } t_result;

endpackage

### sv/particle_sensor_frame_parser_unit.sv
// channel  | direction | handshake         | beat payload
// input    | in        | i_valid / o_stall | i_rx_byte
// result   | out       | o_valid / i_stall | o_frame_status, o_fine_value, o_coarse_value
//
// one byte per cycle sustained while the result side does not stall
// byte register feeds the frame decode, whose result lands in the output register
// synchronous active-low reset: parser back to hunting, readings to 0xFFFF
// a stalled result holds; a new byte is still taken while the output register drains
// depends on psfp_pkg and psfp_core
module particle_sensor_frame_parser_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_rx_byte,
    output logic                    o_valid,
    input  logic                    i_stall,
    output psfp_pkg::t_frame_status o_frame_status,
    output logic [15:0]             o_fine_value,
    output logic [15:0]             o_coarse_value
);
    import psfp_pkg::*;

    logic    r_in_valid;
    logic [7:0] r_in_byte;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    out_ready;
    logic    advance;

    assign out_ready = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    psfp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_status = r_out.status;
    assign o_fine_value   = r_out.fine;
    assign o_coarse_value = r_out.coarse;

endmodule

### sv/psfp_core.sv
// frame tracking state and per-byte decode
// depends on psfp_pkg
module psfp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [7:0]        i_byte,
    output psfp_pkg::t_result o_result
);
    import psfp_pkg::*;

    logic [3:0]  r_pos,     n_pos;
    logic [7:0]  r_command, n_command;
    logic [7:0]  r_sum,     n_sum;
    logic [31:0] r_payload, n_payload;
    logic        r_sum_ok,  n_sum_ok;
    logic [15:0] r_fine,    n_fine;
    logic [15:0] r_coarse,  n_coarse;
    t_frame_status n_status;
    logic [1:0]  lane;

    assign lane = 2'(r_pos - POS_DATA0);

    always_comb begin
        n_pos     = r_pos;
        n_command = r_command;
        n_sum     = r_sum;
        n_payload = r_payload;
        n_sum_ok  = r_sum_ok;
        n_fine    = r_fine;
        n_coarse  = r_coarse;
        n_status  = ST_DISCARD;
        if (r_pos == POS_HUNT) begin
            if (i_byte == START_BYTE) begin
                n_pos    = POS_COMMAND;
                n_status = ST_IN_FRAME;
            end
        end else if (r_pos < POS_TAIL) begin
            if (r_pos == POS_COMMAND) begin
                n_command = i_byte;
            end else if (r_pos < POS_SUM) begin
                n_sum = (r_pos == POS_DATA0) ? i_byte : 8'(r_sum + i_byte);
                if (r_pos <= POS_DATA3) begin
                    case (lane)
                        2'd0:    n_payload[7:0]   = i_byte;
                        2'd1:    n_payload[15:8]  = i_byte;
                        2'd2:    n_payload[23:16] = i_byte;
                        2'd3:    n_payload[31:24] = i_byte;
                        default: n_payload        = r_payload;
                    endcase
                end
            end else begin
                n_sum_ok = (i_byte == r_sum);
            end
            n_pos    = 4'(r_pos + 4'd1);
            n_status = ST_IN_FRAME;
        end else begin
            // tail position, and any stray position past it
            if (i_byte != TAIL_BYTE) begin
                n_status = ST_TAIL_BAD;
            end else if (!r_sum_ok) begin
                n_status = ST_SUM_BAD;
            end else if (r_command == DATA_COMMAND) begin
                n_fine   = r_payload[15:0];
                n_coarse = r_payload[31:16];
                n_status = ST_UPDATED;
            end else begin
                n_status = ST_OTHER;
            end
            n_pos = POS_HUNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_HUNT;
            r_fine   <= READING_INVALID;
            r_coarse <= READING_INVALID;
        end else if (i_advance) begin
            r_pos    <= n_pos;
            r_fine   <= n_fine;
            r_coarse <= n_coarse;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_command <= n_command;
            r_sum     <= n_sum;
            r_payload <= n_payload;
            r_sum_ok  <= n_sum_ok;
        end
    end

    assign o_result.status = n_status;
    assign o_result.fine   = n_fine;
    assign o_result.coarse = n_coarse;

endmodule

### sv/psfp_checker.sv
// port-level checks for particle_sensor_frame_parser_unit, bound to the top level
// depends on psfp_pkg
module psfp_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input psfp_pkg::t_frame_status o_frame_status,
    input logic [15:0]             o_fine_value,
    input logic [15:0]             o_coarse_value
);
    import psfp_pkg::*;

    logic        r_seen;
    logic [15:0] r_last_fine;
    logic [15:0] r_last_coarse;

    // readings of the last delivered beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_valid && !i_stall) begin
            r_seen        <= 1'b1;
            r_last_fine   <= o_fine_value;
            r_last_coarse <= o_coarse_value;
        end
    end

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_status)
            && $stable(o_fine_value) && $stable(o_coarse_value))
        else $error("stalled result beat changed");

    a_readings_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_seen && o_frame_status != ST_UPDATED
            |-> o_fine_value == r_last_fine && o_coarse_value == r_last_coarse)
        else $error("readings changed without a good data frame");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_frame_status == ST_DISCARD || o_frame_status == ST_IN_FRAME
            || o_frame_status == ST_UPDATED || o_frame_status == ST_OTHER
            || o_frame_status == ST_SUM_BAD || o_frame_status == ST_TAIL_BAD)
        else $error("illegal frame status");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while result side free");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind particle_sensor_frame_parser_unit psfp_checker u_psfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_frame_status (o_frame_status),
    .o_fine_value   (o_fine_value),
    .o_coarse_value (o_coarse_value)
);
